>>> rtl/core/joystick_axis_conditioner_assert.svh
// Assertion macros for the joystick axis conditioner RTL.
// Included by files that assert; depends on nothing else.
`ifndef JOYSTICK_AXIS_CONDITIONER_ASSERT_SVH
`define JOYSTICK_AXIS_CONDITIONER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define JAC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("joystick_axis_conditioner: assertion failed");

// Next-cycle implication, off during reset.
`define JAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("joystick_axis_conditioner: assertion failed");

`endif

>>> rtl/core/jac_pkg.sv
// Shared constants, register codes and types of the joystick axis conditioner.
// No dependencies.
package jac_pkg;

  localparam int unsigned AXIS_N    = 4;
  localparam int unsigned AXIS_IW   = 2;   // axis index bits
  localparam int unsigned RAW_W     = 12;
  localparam int unsigned VAL_W     = 13;  // inverted axes reach 4096
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned NUM_W     = 18;  // 50 * 4096 fits
  localparam int unsigned Q_W       = 6;   // quotient never above 50
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [VAL_W-1:0]     FULL_SCALE = 13'd4096;
  localparam logic [Q_W-1:0]       PCT_SPAN   = 6'd50;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST   = 5'(NUM_W - 1);

  localparam logic [RAW_W-1:0] CENTER_RST   = 12'd2000;
  localparam logic [VAL_W-1:0] DEADBAND_RST = 13'd30;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_AXIS = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [VAL_W-1:0] den;
  } div_ctrl_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_sts_t;

endpackage

>>> rtl/core/jac_cfg.sv
// Configuration registers: four axis centers and the deadband.
// Depends on jac_pkg.
module jac_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jac_pkg::VAL_W-1:0]      cfg_wdata_i,
  input  logic [jac_pkg::AXIS_IW-1:0]    axis_sel_i,
  output logic [jac_pkg::RAW_W-1:0]      center_o,
  output logic [jac_pkg::VAL_W-1:0]      deadband_o
);

  logic [jac_pkg::RAW_W-1:0] center_q [jac_pkg::AXIS_N];
  logic [jac_pkg::VAL_W-1:0] deadband_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < jac_pkg::AXIS_N; i++) center_q[i] <= jac_pkg::CENTER_RST;
      deadband_q <= jac_pkg::DEADBAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jac_pkg::REG_CENTER_SPEED, jac_pkg::REG_CENTER_X,
        jac_pkg::REG_CENTER_Y, jac_pkg::REG_CENTER_Z: begin
          center_q[cfg_idx_i[jac_pkg::AXIS_IW-1:0]] <= cfg_wdata_i[jac_pkg::RAW_W-1:0];
        end
        jac_pkg::REG_DEADBAND: begin
          deadband_q <= cfg_wdata_i;
        end
        default: ;  // unused index, dropped
      endcase
    end
  end

  assign center_o   = center_q[axis_sel_i];
  assign deadband_o = deadband_q;

endmodule

>>> rtl/core/jac_div.sv
// Bit-serial restoring divider: one numerator bit per cycle, 6-bit quotient.
// Depends on jac_pkg.
module jac_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jac_pkg::div_ctrl_t ctrl_i,
  output jac_pkg::div_sts_t  sts_o
);

  logic [jac_pkg::NUM_W-1:0]     num_q;
  logic [jac_pkg::VAL_W-1:0]     den_q;
  logic [jac_pkg::VAL_W-1:0]     rem_q, rem_d;
  logic [jac_pkg::Q_W-1:0]       quot_q;
  logic [jac_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q, done_q;
  logic [jac_pkg::VAL_W:0]       trial;
  logic                          qbit;

  // shift next numerator bit into the partial remainder
  assign trial = {rem_q, num_q[jac_pkg::NUM_W-1]};
  assign qbit  = trial >= {1'b0, den_q};
  assign rem_d = qbit ? jac_pkg::VAL_W'(trial - {1'b0, den_q})
                      : trial[jac_pkg::VAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == jac_pkg::DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && !busy_q) begin
      num_q  <= ctrl_i.num;
      den_q  <= ctrl_i.den;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[jac_pkg::NUM_W-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[jac_pkg::Q_W-2:0], qbit};
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.quot = quot_q;

endmodule

>>> rtl/core/joystick_axis_conditioner.sv
// Joystick axis conditioner top level: deadband tracking and center scaling.
// Depends on jac_pkg, jac_cfg, jac_div and joystick_axis_conditioner_assert.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | to block  | in_valid_i/in_stall_o  | raw_speed_i raw_x_i raw_y_i raw_z_i
//  out     | from block| out_valid_o/out_stall_i| speed_pct_o x_pct_o y_pct_o z_pct_o
//          |           |                        | changed_o
//  cfg     | to block  | cfg_we_i               | cfg_idx_i cfg_wdata_i
//
// Each word is worked through per axis: a setup state, the shared bit-serial
// divider, which takes in the numerator a bit at a time, and a collect step;
// then the output register is loaded as soon as it is free, and only then is
// a new word accepted.
// Reset clears control state, the centers (2000), the deadband (30) and the
// last reported axis values (0).
// A finished word waits in the output register under out_stall_i; a new input
// word is taken meanwhile, and its result waits for the register to free up.
module joystick_axis_conditioner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [jac_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [jac_pkg::VAL_W-1:0]           cfg_wdata_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [jac_pkg::RAW_W-1:0]           raw_speed_i,
  input  logic [jac_pkg::RAW_W-1:0]           raw_x_i,
  input  logic [jac_pkg::RAW_W-1:0]           raw_y_i,
  input  logic [jac_pkg::RAW_W-1:0]           raw_z_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [jac_pkg::PCT_W-1:0]    speed_pct_o,
  output logic signed [jac_pkg::PCT_W-1:0]    x_pct_o,
  output logic signed [jac_pkg::PCT_W-1:0]    y_pct_o,
  output logic signed [jac_pkg::PCT_W-1:0]    z_pct_o,
  output logic                                changed_o
);

`include "joystick_axis_conditioner_assert.svh"

  jac_pkg::state_e state_q, state_d;

  logic [jac_pkg::AXIS_IW-1:0] axis_q;
  logic [jac_pkg::VAL_W-1:0]   cur_q  [jac_pkg::AXIS_N];  // captured axis values
  logic [jac_pkg::VAL_W-1:0]   last_q [jac_pkg::AXIS_N];  // last reported values
  logic [jac_pkg::PCT_W-1:0]   pct_q  [jac_pkg::AXIS_N];
  logic                        neg_q;
  logic                        chg_q;

  logic                        out_valid_q;
  logic [jac_pkg::PCT_W-1:0]   speed_q, x_q, y_q, z_q;
  logic                        changed_q;

  logic                        in_acc;
  logic                        out_free;
  logic                        fin_go;      // result moves into the output register
  logic                        first_axis;  // setup of the speed axis

  logic [jac_pkg::RAW_W-1:0]   center;
  logic [jac_pkg::VAL_W-1:0]   deadband;
  logic [jac_pkg::VAL_W-1:0]   val, cval, last, diff, mag;
  logic                        upd, ge;
  logic [jac_pkg::NUM_W-1:0]   mag_w;
  logic [jac_pkg::PCT_W-1:0]   qext;

  jac_pkg::div_ctrl_t div_ctrl;
  jac_pkg::div_sts_t  div_sts;

  jac_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .axis_sel_i (axis_q),
    .center_o   (center),
    .deadband_o (deadband)
  );

  jac_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(div_ctrl),
    .sts_o (div_sts)
  );

  assign in_stall_o = state_q != jac_pkg::S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_go     = state_q == jac_pkg::S_FIN && out_free;
  assign first_axis = state_q == jac_pkg::S_AXIS && axis_q == '0;

  // Per-axis setup: deadband test against the last reported value, and the
  // numerator/denominator for the scaling divide.
  assign val  = cur_q[axis_q];
  assign last = last_q[axis_q];
  assign cval = {1'b0, center};
  assign diff = (val >= last) ? val - last : last - val;
  assign upd  = diff > deadband;
  assign ge   = val >= cval;
  assign mag  = ge ? val - cval : cval - val;
  assign mag_w = jac_pkg::NUM_W'(mag);
  // 50 * mag as 32 + 16 + 2
  assign div_ctrl.num   = (mag_w << 5) + (mag_w << 4) + (mag_w << 1);
  assign div_ctrl.den   = ge ? jac_pkg::FULL_SCALE - cval : cval;
  assign div_ctrl.start = state_q == jac_pkg::S_AXIS;

  assign qext = {1'b0, div_sts.quot};

  always_comb begin
    state_d = state_q;
    case (state_q)
      jac_pkg::S_IDLE: if (in_acc) state_d = jac_pkg::S_AXIS;
      jac_pkg::S_AXIS: state_d = jac_pkg::S_DIV;
      jac_pkg::S_DIV: begin
        if (div_sts.done) begin
          state_d = (axis_q == jac_pkg::AXIS_IW'(jac_pkg::AXIS_N - 1)) ? jac_pkg::S_FIN
                                                                      : jac_pkg::S_AXIS;
        end
      end
      jac_pkg::S_FIN: if (out_free) state_d = jac_pkg::S_IDLE;
      default: state_d = jac_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jac_pkg::S_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < jac_pkg::AXIS_N; i++) last_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) axis_q <= '0;
      else if (state_q == jac_pkg::S_DIV && div_sts.done) axis_q <= axis_q + 1'b1;
      if (state_q == jac_pkg::S_AXIS && upd) last_q[axis_q] <= val;
      if (state_q == jac_pkg::S_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q[0] <= {1'b0, raw_speed_i};
      cur_q[1] <= {1'b0, raw_x_i};
      cur_q[2] <= jac_pkg::FULL_SCALE - {1'b0, raw_y_i};  // y and z run inverted
      cur_q[3] <= jac_pkg::FULL_SCALE - {1'b0, raw_z_i};
      chg_q    <= 1'b0;
    end
    if (state_q == jac_pkg::S_AXIS) begin
      neg_q <= !ge;
      if (upd) chg_q <= 1'b1;
    end
    if (state_q == jac_pkg::S_DIV && div_sts.done) begin
      pct_q[axis_q] <= neg_q ? -qext : qext;
    end
    if (state_q == jac_pkg::S_FIN && out_free) begin
      speed_q   <= pct_q[0];
      x_q       <= pct_q[1];
      y_q       <= pct_q[2];
      z_q       <= pct_q[3];
      changed_q <= chg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign speed_pct_o = speed_q;
  assign x_pct_o     = x_q;
  assign y_pct_o     = y_q;
  assign z_pct_o     = z_q;
  assign changed_o   = changed_q;

  `JAC_ASSERT_IMPL(a_done_in_div, clk_i, rst_ni, div_sts.done, state_q == jac_pkg::S_DIV)
  `JAC_ASSERT_IMPL(a_quot_range, clk_i, rst_ni, div_sts.done, div_sts.quot <= jac_pkg::PCT_SPAN)
  `JAC_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_acc, first_axis)
  `JAC_ASSERT_NEXT(a_fin_delivers, clk_i, rst_ni, fin_go, out_valid_q && !in_stall_o)

endmodule
